/* src/echo_ranging_pi_position_control_core_macros.svh */
// Assertion macros shared by the echo ranging PI position control RTL.
// Every file that asserts includes this header; it depends on nothing else.
`ifndef ECHO_RANGING_PI_POSITION_CONTROL_CORE_MACROS_SVH
`define ECHO_RANGING_PI_POSITION_CONTROL_CORE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ERPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset cycles included.
`define ERPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/erpc_pkg.sv */
// Package for the echo ranging PI position control core: event and register codes,
// configuration and pipeline control types, reset values and divider constants.
// No dependencies.
`default_nettype none

package erpc_pkg;

   // Event kinds carried by the func field of a request.
   typedef enum logic [1:0] {
      FUNC_RISE = 2'd0,
      FUNC_FALL = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_TARGET      = 3'd2,
      CSR_DRIVE_EN    = 3'd3,
      CSR_FLOOR_ONE   = 3'd4,
      CSR_FLOOR_TWO   = 3'd5,
      CSR_FLOOR_THREE = 3'd6,
      CSR_FLOOR_TOL   = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef struct packed {
      logic [7:0] gain_p;
      logic [7:0] gain_i;
      logic [7:0] target_distance;
      logic       drive_enable;
      logic [7:0] floor_one_cm;
      logic [7:0] floor_two_cm;
      logic [7:0] floor_three_cm;
      logic [4:0] floor_tolerance;
   } cfg_type;

   localparam logic [7:0] GAIN_P_RST      = 8'd30;
   localparam logic [7:0] GAIN_I_RST      = 8'd5;
   localparam logic [7:0] TARGET_RST      = 8'd100;
   localparam logic       DRIVE_EN_RST    = 1'b0;
   localparam logic [7:0] FLOOR_ONE_RST   = 8'd20;
   localparam logic [7:0] FLOOR_TWO_RST   = 8'd60;
   localparam logic [7:0] FLOOR_THREE_RST = 8'd100;
   localparam logic [4:0] FLOOR_TOL_RST   = 5'd2;

   // Pipeline: stage 0 is the request register, stage 7 the response register.
   localparam int NUM_STAGES = 8;

   typedef struct packed {
      logic [NUM_STAGES-1:0] step;   // a valid transaction loads stage k
      logic [NUM_STAGES-1:0] valid;  // stage k holds a transaction
   } stage_ctl_type;

   // Timing parameter defaults.
   localparam int OVERFLOW_TICKS_DEF = 65536;
   localparam int TICKS_PER_US_DEF   = 8;
   localparam int US_PER_CM_DEF      = 58;

   // A reading is kept only strictly between these bounds.
   localparam logic [31:0] DIST_LOW  = 32'd5;
   localparam logic [31:0] DIST_HIGH = 32'd150;

   localparam logic signed [15:0] DRIVE_LIMIT = 16'sd255;

   // Exact reciprocal multipliers: x / 10 for x < 2^17, x / 1000 for x < 2^23.
   localparam logic [17:0] TENTH_MULT  = 18'd209716;
   localparam int          TENTH_SHIFT = 21;
   localparam logic [23:0] MILLI_MULT  = 24'd8589935;
   localparam int          MILLI_SHIFT = 33;

endpackage

`default_nettype wire

/* src/erpc_req_if.sv */
// Request channel interface: valid/ready handshake with the echo event payload.
// No dependencies.
`default_nettype none

interface erpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] capture_time;
   logic [7:0]  overflow_count;

   modport source (output valid, func, capture_time, overflow_count, input ready);
   modport sink   (input valid, func, capture_time, overflow_count, output ready);
endinterface

`default_nettype wire

/* src/erpc_rsp_if.sv */
// Response channel interface: valid/ready handshake with the distance and drive payload.
// No dependencies.
`default_nettype none

interface erpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] distance_cm;
   logic       reading_accepted;
   logic [1:0] floor_number;
   logic [7:0] drive_up;
   logic [7:0] drive_down;
   logic       drive_updated;

   modport source (output valid, distance_cm, reading_accepted, floor_number,
                   drive_up, drive_down, drive_updated, input ready);
   modport sink   (input valid, distance_cm, reading_accepted, floor_number,
                   drive_up, drive_down, drive_updated, output ready);
endinterface

`default_nettype wire

/* src/erpc_csr.sv */
// Configuration register file of the echo ranging PI position control core.
// Depends on erpc_pkg.
`default_nettype none

module erpc_csr
   import erpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg,
   output logic                        integ_clear
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in      = cfg_ff;
      integ_clear = 1'b0;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:      cfg_in.gain_p = csr_wdata;
            CSR_GAIN_I:      cfg_in.gain_i = csr_wdata;
            CSR_TARGET: begin
               // Only a changed set point restarts the integrator.
               if (csr_wdata != cfg_ff.target_distance) begin
                  cfg_in.target_distance = csr_wdata;
                  integ_clear            = 1'b1;
               end
            end
            CSR_DRIVE_EN:    cfg_in.drive_enable    = csr_wdata[0];
            CSR_FLOOR_ONE:   cfg_in.floor_one_cm    = csr_wdata;
            CSR_FLOOR_TWO:   cfg_in.floor_two_cm    = csr_wdata;
            CSR_FLOOR_THREE: cfg_in.floor_three_cm  = csr_wdata;
            CSR_FLOOR_TOL:   cfg_in.floor_tolerance = csr_wdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= GAIN_P_RST;
         cfg_ff.gain_i          <= GAIN_I_RST;
         cfg_ff.target_distance <= TARGET_RST;
         cfg_ff.drive_enable    <= DRIVE_EN_RST;
         cfg_ff.floor_one_cm    <= FLOOR_ONE_RST;
         cfg_ff.floor_two_cm    <= FLOOR_TWO_RST;
         cfg_ff.floor_three_cm  <= FLOOR_THREE_RST;
         cfg_ff.floor_tolerance <= FLOOR_TOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* src/erpc_range.sv */
// Echo pulse measurement stages: rising edge capture, pulse width and division by the
// ticks per centimeter through a reciprocal multiply with remainder correction.
// Depends on erpc_pkg and the assertion macro header.
`default_nettype none
`include "echo_ranging_pi_position_control_core_macros.svh"

module erpc_range
   import erpc_pkg::*;
#(
   parameter int OVERFLOW_TICKS = OVERFLOW_TICKS_DEF,
   parameter int TICKS_PER_US   = TICKS_PER_US_DEF,
   parameter int US_PER_CM      = US_PER_CM_DEF
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire stage_ctl_type ctl,
   input  wire logic [1:0]   func_s0,
   input  wire logic [15:0]  time_s0,
   input  wire logic [7:0]   ovf_s0,
   output logic [1:0]        func_s3,
   output logic [31:0]       dist_quot
);

   localparam int          DIVISOR   = TICKS_PER_US * US_PER_CM;
   localparam logic [31:0] DIVISOR_W = 32'(DIVISOR);
   localparam logic [31:0] OVF_W     = 32'(OVERFLOW_TICKS);
   // floor(2^32 / DIVISOR) underestimates the quotient by at most one.
   localparam logic [32:0] RECIP     = 33'((64'd1 << 32) / 64'(DIVISOR));

   logic [15:0] rise_time_ff;
   logic [7:0]  rise_ovf_ff;
   logic [31:0] width_in;
   logic [1:0]  func_s1_ff;
   logic [31:0] width_s1_ff;
   logic [64:0] recip_prod;
   logic [1:0]  func_s2_ff;
   logic [31:0] width_s2_ff;
   logic [31:0] quot_s2_ff;
   logic [1:0]  func_s3_ff;
   logic [31:0] quot_s3_ff;
   logic [31:0] rem_s3_ff;

   // Pulse width in wrapping 32-bit arithmetic.
   assign width_in = (32'(time_s0) - 32'(rise_time_ff))
                   + OVF_W * (32'(ovf_s0) - 32'(rise_ovf_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_time_ff <= '0;
         rise_ovf_ff  <= '0;
      end else if (ctl.step[1] && func_s0 == FUNC_RISE) begin
         rise_time_ff <= time_s0;
         rise_ovf_ff  <= ovf_s0;
      end
   end

   assign recip_prod = {33'd0, width_s1_ff} * {32'd0, RECIP};

   always_ff @(posedge clock) begin
      if (ctl.step[1]) begin
         func_s1_ff  <= func_s0;
         width_s1_ff <= width_in;
      end
      if (ctl.step[2]) begin
         func_s2_ff  <= func_s1_ff;
         width_s2_ff <= width_s1_ff;
         quot_s2_ff  <= recip_prod[63:32];
      end
      if (ctl.step[3]) begin
         func_s3_ff <= func_s2_ff;
         quot_s3_ff <= quot_s2_ff;
         rem_s3_ff  <= width_s2_ff - quot_s2_ff * DIVISOR_W;
      end
   end

   assign func_s3   = func_s3_ff;
   assign dist_quot = quot_s3_ff + {31'd0, (rem_s3_ff >= DIVISOR_W)};

   // The estimate is never more than one below the true quotient.
   `ERPC_ASSERT(a_rem_bound, ctl.valid[3] |-> rem_s3_ff < (DIVISOR_W << 1), "remainder out of range")

endmodule

`default_nettype wire

/* src/erpc_ctrl.sv */
// Distance acceptance, integrator, PI arithmetic and drive split of the position loop,
// stages four to seven of the pipeline. Depends on erpc_pkg and the assertion macros.
`default_nettype none
`include "echo_ranging_pi_position_control_core_macros.svh"

module erpc_ctrl
   import erpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl,
   input  wire cfg_type       cfg,
   input  wire logic          integ_clear,
   input  wire logic [1:0]    func_s3,
   input  wire logic [31:0]   dist_quot,
   output logic [7:0]         dist_s6,
   output logic               accepted_s6,
   output logic [1:0]         floor_s6,
   output logic               tick_s6,
   output logic [7:0]         drive_up,
   output logic [7:0]         drive_down
);

   localparam logic signed [31:0] INTEG_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INTEG_MIN = 32'sh8000_0000;

   function automatic logic near_floor(input logic [7:0] d, input logic [7:0] fl,
                                       input logic [4:0] tol);
      logic signed [9:0] lo;
      logic [8:0]        hi;
      lo = $signed({2'b00, fl}) - $signed({5'b00000, tol});
      hi = {1'b0, fl} + {4'b0000, tol};
      return (lo <= $signed({2'b00, d})) && ({1'b0, d} <= hi);
   endfunction

   // Stage 4: distance and integrator state.
   logic [7:0]         dist_ff;
   logic signed [31:0] integ_ff;
   logic               in_range;
   logic               accepted_in;
   logic               run_in;
   logic signed [8:0]  err_in;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic [7:0]         dist_now;

   logic               accepted_s4_ff, tick_s4_ff, run_s4_ff;
   logic [7:0]         dist_s4_ff;
   logic signed [8:0]  err_s4_ff;
   logic signed [31:0] sum_s4_ff;

   // Stage 5: gain products and floor.
   logic signed [17:0] pe_in;
   logic signed [40:0] pi_in;
   logic [1:0]         floor_in;
   logic               accepted_s5_ff, tick_s5_ff, run_s5_ff;
   logic [7:0]         dist_s5_ff;
   logic [1:0]         floor_s5_ff;
   logic signed [17:0] pe_s5_ff;
   logic signed [40:0] pi_s5_ff;

   // Stage 6: truncating divides by ten and by one thousand.
   logic [17:0]        a_abs;
   logic [40:0]        b_abs;
   logic [22:0]        b_cap;
   logic [34:0]        a_prod;
   logic [46:0]        b_prod;
   logic               accepted_s6_ff, tick_s6_ff, run_s6_ff;
   logic [7:0]         dist_s6_ff;
   logic [1:0]         floor_s6_ff;
   logic               a_neg_s6_ff, b_neg_s6_ff;
   logic [12:0]        qa_s6_ff;
   logic [13:0]        qb_s6_ff;

   // Stage 7: drive clip and split.
   logic signed [15:0] a_val, b_val, drive_sum, drive_neg;
   logic [7:0]         up_in, down_in;
   logic [7:0]         drive_up_ff, drive_down_ff;

   assign in_range    = (dist_quot > DIST_LOW) && (dist_quot < DIST_HIGH);
   assign accepted_in = (func_s3 == FUNC_FALL) && in_range;
   assign run_in      = (func_s3 == FUNC_TICK) && cfg.drive_enable;
   assign dist_now    = accepted_in ? dist_quot[7:0] : dist_ff;
   assign err_in      = $signed({1'b0, cfg.target_distance}) - $signed({1'b0, dist_ff});
   assign sum_wide    = {integ_ff[31], integ_ff} + {{24{err_in[8]}}, err_in};

   always_comb begin
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? INTEG_MIN : INTEG_MAX;
      end else begin
         sum_sat = sum_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff  <= '0;
         integ_ff <= '0;
      end else begin
         if (ctl.step[4] && accepted_in) begin
            dist_ff <= dist_quot[7:0];
         end
         if (integ_clear) begin
            integ_ff <= '0;
         end else if (ctl.step[4] && run_in) begin
            integ_ff <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step[4]) begin
         accepted_s4_ff <= accepted_in;
         tick_s4_ff     <= (func_s3 == FUNC_TICK);
         run_s4_ff      <= run_in;
         dist_s4_ff     <= dist_now;
         err_s4_ff      <= err_in;
         sum_s4_ff      <= sum_sat;
      end
   end

   assign pe_in = err_s4_ff * $signed({1'b0, cfg.gain_p});
   assign pi_in = sum_s4_ff * $signed({1'b0, cfg.gain_i});

   always_comb begin
      if (near_floor(dist_s4_ff, cfg.floor_one_cm, cfg.floor_tolerance)) begin
         floor_in = 2'd1;
      end else if (near_floor(dist_s4_ff, cfg.floor_two_cm, cfg.floor_tolerance)) begin
         floor_in = 2'd2;
      end else if (near_floor(dist_s4_ff, cfg.floor_three_cm, cfg.floor_tolerance)) begin
         floor_in = 2'd3;
      end else begin
         floor_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step[5]) begin
         accepted_s5_ff <= accepted_s4_ff;
         tick_s5_ff     <= tick_s4_ff;
         run_s5_ff      <= run_s4_ff;
         dist_s5_ff     <= dist_s4_ff;
         floor_s5_ff    <= floor_in;
         pe_s5_ff       <= pe_in;
         pi_s5_ff       <= pi_in;
      end
   end

   // Divide magnitudes so that both quotients truncate toward zero.
   assign a_abs  = pe_s5_ff[17] ? 18'(-pe_s5_ff) : 18'(pe_s5_ff);
   assign b_abs  = pi_s5_ff[40] ? 41'(-pi_s5_ff) : 41'(pi_s5_ff);
   // Past 2^23 the integral term alone saturates the drive, so the cap keeps the clip.
   assign b_cap  = (b_abs[40:23] != '0) ? {23{1'b1}} : b_abs[22:0];
   assign a_prod = {18'd0, a_abs[16:0]} * {17'd0, TENTH_MULT};
   assign b_prod = {24'd0, b_cap} * {23'd0, MILLI_MULT};

   always_ff @(posedge clock) begin
      if (ctl.step[6]) begin
         accepted_s6_ff <= accepted_s5_ff;
         tick_s6_ff     <= tick_s5_ff;
         run_s6_ff      <= run_s5_ff;
         dist_s6_ff     <= dist_s5_ff;
         floor_s6_ff    <= floor_s5_ff;
         a_neg_s6_ff    <= pe_s5_ff[17];
         b_neg_s6_ff    <= pi_s5_ff[40];
         qa_s6_ff       <= a_prod[TENTH_SHIFT +: 13];
         qb_s6_ff       <= b_prod[MILLI_SHIFT +: 14];
      end
   end

   assign a_val     = a_neg_s6_ff ? -$signed(16'(qa_s6_ff)) : $signed(16'(qa_s6_ff));
   assign b_val     = b_neg_s6_ff ? -$signed(16'(qb_s6_ff)) : $signed(16'(qb_s6_ff));
   assign drive_sum = a_val + b_val;
   assign drive_neg = -drive_sum;

   always_comb begin
      up_in   = '0;
      down_in = '0;
      if (run_s6_ff) begin
         if (drive_sum > DRIVE_LIMIT) begin
            up_in = 8'd255;
         end else if (drive_sum < -DRIVE_LIMIT) begin
            down_in = 8'd255;
         end else if (!drive_sum[15]) begin
            up_in = drive_sum[7:0];
         end else begin
            down_in = drive_neg[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_up_ff   <= '0;
         drive_down_ff <= '0;
      end else if (ctl.step[7] && tick_s6_ff) begin
         drive_up_ff   <= up_in;
         drive_down_ff <= down_in;
      end
   end

   assign dist_s6     = dist_s6_ff;
   assign accepted_s6 = accepted_s6_ff;
   assign floor_s6    = floor_s6_ff;
   assign tick_s6     = tick_s6_ff;
   assign drive_up    = drive_up_ff;
   assign drive_down  = drive_down_ff;

   `ERPC_ASSERT(a_integ_clear, integ_clear |=> integ_ff == 32'sd0, "integrator not cleared")
   `ERPC_ASSERT(a_drive_off, ctl.step[7] && tick_s6_ff && !run_s6_ff |=> drive_up_ff == 8'd0 && drive_down_ff == 8'd0, "disabled tick left a drive")

endmodule

`default_nettype wire

/* src/echo_ranging_pi_position_control_core.sv */
// Echo ranging PI position control core: ultrasonic echo distance meter with a PI loop
// that drives an up and a down motor output. A request transaction carries an event:
// an echo rising edge stores the capture time and overflow count, an echo falling edge
// turns the pulse width into a distance in centimeters (kept only when it lies strictly
// between 5 and 150), and a control tick runs the PI loop, or forces both drives to zero
// when drive_enable is clear. Every request yields exactly one response transaction, in
// order, carrying the current distance, the floor it lies at (0 when in transit), the
// present drives and two flags. The core is an eight-stage pipeline: request register,
// pulse width, reciprocal multiply, remainder, distance and integrator update, gain
// multiplies, constant divides, and the response register with the drive clip. One
// transaction is taken per cycle while responses are accepted; each stage advances
// whenever the one after it is empty or moving, so a stalled response only holds the
// request side once every stage is occupied. Configuration registers are to be written
// through csr_we/csr_index/csr_wdata only while the core is idle, which the core itself
// does not enforce; writing a different target distance clears the integrator.
//
// Depends on erpc_pkg, erpc_req_if, erpc_rsp_if, erpc_csr, erpc_range, erpc_ctrl and the
// assertion macro header.
`default_nettype none
`include "echo_ranging_pi_position_control_core_macros.svh"

module echo_ranging_pi_position_control_core
   import erpc_pkg::*;
#(
   parameter int OVERFLOW_TICKS = OVERFLOW_TICKS_DEF,
   parameter int TICKS_PER_US   = TICKS_PER_US_DEF,
   parameter int US_PER_CM      = US_PER_CM_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   erpc_req_if.sink                    req_ch,
   erpc_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Pipeline occupancy. The last stage is the response register itself.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] free;
   logic [NUM_STAGES-1:0] step;
   stage_ctl_type         ctl;

   cfg_type     cfg;
   logic        integ_clear;

   // Request register.
   logic [1:0]  func_s0_ff;
   logic [15:0] time_s0_ff;
   logic [7:0]  ovf_s0_ff;

   logic [1:0]  func_s3;
   logic [31:0] dist_quot;
   logic [7:0]  dist_s6;
   logic        accepted_s6;
   logic [1:0]  floor_s6;
   logic        tick_s6;
   logic [7:0]  drive_up;
   logic [7:0]  drive_down;

   // Response register payload; the drives come straight from the drive state, which
   // changes only when this register loads.
   logic [7:0]  dist_rsp_ff;
   logic        accepted_rsp_ff;
   logic [1:0]  floor_rsp_ff;
   logic        tick_rsp_ff;

   // A stage may load when it is empty or its content moves on in this cycle.
   always_comb begin
      free[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
   end

   always_comb begin
      step[0]     = req_ch.valid && free[0];
      valid_in[0] = free[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         step[k]     = free[k] && valid_ff[k-1];
         valid_in[k] = free[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.step  = step;
   assign ctl.valid = valid_ff;

   assign req_ch.ready = free[0];

   always_ff @(posedge clock) begin
      if (step[0]) begin
         func_s0_ff <= req_ch.func;
         time_s0_ff <= req_ch.capture_time;
         ovf_s0_ff  <= req_ch.overflow_count;
      end
   end

   erpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .integ_clear (integ_clear)
   );

   erpc_range #(
      .OVERFLOW_TICKS (OVERFLOW_TICKS),
      .TICKS_PER_US   (TICKS_PER_US),
      .US_PER_CM      (US_PER_CM)
   ) u_range (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .func_s0   (func_s0_ff),
      .time_s0   (time_s0_ff),
      .ovf_s0    (ovf_s0_ff),
      .func_s3   (func_s3),
      .dist_quot (dist_quot)
   );

   erpc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cfg         (cfg),
      .integ_clear (integ_clear),
      .func_s3     (func_s3),
      .dist_quot   (dist_quot),
      .dist_s6     (dist_s6),
      .accepted_s6 (accepted_s6),
      .floor_s6    (floor_s6),
      .tick_s6     (tick_s6),
      .drive_up    (drive_up),
      .drive_down  (drive_down)
   );

   always_ff @(posedge clock) begin
      if (step[NUM_STAGES-1]) begin
         dist_rsp_ff     <= dist_s6;
         accepted_rsp_ff <= accepted_s6;
         floor_rsp_ff    <= floor_s6;
         tick_rsp_ff     <= tick_s6;
      end
   end

   assign rsp_ch.valid            = valid_ff[NUM_STAGES-1];
   assign rsp_ch.distance_cm      = dist_rsp_ff;
   assign rsp_ch.reading_accepted = accepted_rsp_ff;
   assign rsp_ch.floor_number     = floor_rsp_ff;
   assign rsp_ch.drive_up         = drive_up;
   assign rsp_ch.drive_down       = drive_down;
   assign rsp_ch.drive_updated    = tick_rsp_ff;

   // Reset empties every stage, so no stale transaction can surface afterwards.
   `ERPC_ASSERT_ALWAYS(a_reset_empty, reset |=> valid_ff == '0, "pipeline not empty after reset")
   // An accepted request always lands in the request register.
   `ERPC_ASSERT(a_accept_loads, req_ch.valid && req_ch.ready |=> valid_ff[0], "accepted request lost")
   // A held response blocks the last internal stage from overwriting it.
   `ERPC_ASSERT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready |-> !step[NUM_STAGES-1], "response overwritten while stalled")

endmodule

`default_nettype wire
